FILE: sv/sta_pkg.sv
// Package for the slot table allocator: sizes, operation and status codes,
// and the word and probe types shared by the top level and the slot cells.
// Depends on nothing.
`default_nettype none

package sta_pkg;

    localparam int SLOTS      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);

    // Input kind codes
    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_RM_SLOT  = 2'd1;
    localparam logic [1:0] KIND_RM_VALUE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Operation carried by a probe along the cell chain
    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_RM_SLOT  = 2'd1;
    localparam logic [1:0] OP_RM_VALUE = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [5:0]  slot;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] used_slot;
        logic [6:0] removed;
        logic [6:0] entry_total;
    } t_out_word;

    // Probe word: one operation walking the chain plus its running results
    typedef struct packed {
        logic                  valid;
        logic [1:0]            op;
        logic [DATA_WIDTH-1:0] value;
        logic [IDX_W-1:0]      target;
        logic [IDX_W-1:0]      idx;
        logic [CNT_W-1:0]      hw;
        logic [CNT_W-1:0]      removed;
        logic                  free_found;
        logic [IDX_W-1:0]      free_idx;
        logic                  clr_found;
        logic [IDX_W-1:0]      clr_idx;
        logic                  top_hit;
    } t_probe;

endpackage

`default_nettype wire

FILE: sv/sta_cell.sv
// One slot of the table: holds the data word and valid bit, applies the
// passing probe to itself and forwards the updated probe to the next slot.
// Depends on sta_pkg.
`default_nettype none

module sta_cell
    import sta_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_probe i_probe,
    output t_probe      o_probe
);

    logic                  r_valid;
    logic                  n_valid;
    logic [DATA_WIDTH-1:0] r_data;
    t_probe                r_probe;
    t_probe                n_probe;
    logic                  w_in_range;
    logic                  w_ins;
    logic                  w_clr;

    // Decide what this slot does with the probe
    always_comb begin
        w_in_range = CNT_W'(i_probe.idx) < i_probe.hw;
        w_ins = i_probe.valid && (i_probe.op == OP_INSERT) && (i_probe.idx == i_probe.target);
        w_clr = i_probe.valid && r_valid && w_in_range &&
                (((i_probe.op == OP_RM_SLOT) && (i_probe.idx == i_probe.target)) ||
                 ((i_probe.op == OP_RM_VALUE) && (r_data == i_probe.value)));
        n_valid = w_ins ? 1'b1 : (w_clr ? 1'b0 : r_valid);
    end

    // Fold this slot into the running results and advance the index
    always_comb begin
        n_probe         = i_probe;
        n_probe.idx     = i_probe.idx + IDX_W'(1);
        n_probe.removed = i_probe.removed + CNT_W'(w_clr);
        if (!i_probe.clr_found && w_clr) begin
            n_probe.clr_found = 1'b1;
            n_probe.clr_idx   = i_probe.idx;
        end
        if (!i_probe.free_found && !n_valid) begin
            n_probe.free_found = 1'b1;
            n_probe.free_idx   = i_probe.idx;
        end
        if (w_clr && ((CNT_W'(i_probe.idx) + CNT_W'(1)) == i_probe.hw)) begin
            n_probe.top_hit = 1'b1;
        end
    end

    // Hold slot state and pass the probe on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_probe.valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_probe <= n_probe;
        end
    end

    // Store the data word on insert
    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            r_data <= i_probe.value;
        end
    end

    assign o_probe = r_probe;

endmodule

`default_nettype wire

FILE: sv/slot_table_allocator_top.sv
// Slot table allocator: one probe per command walks a row of slot cells,
// followed by the table counters, free pointer and the result register.
// Depends on sta_pkg and sta_cell.
//
// The table holds SLOTS nonzero data words, one per slot cell, with a
// lowest-free pointer, a high-water mark and an entry count. Each accepted
// command word launches a probe that passes through the cells one per cycle;
// every cell updates its own slot and the running results (slots cleared,
// first free slot, first cleared slot, top slot hit). The block takes one
// command at a time: a command holds the block through launch, the cell
// chain, wrap-up and the move of its result into the output register, which
// waits while a stalled result is held there. A finished result waits in
// the output register while the next command word is already accepted.
`default_nettype none

module slot_table_allocator_top
    import sta_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    logic [IDX_W-1:0]      r_low;
    logic [IDX_W-1:0]      n_low;
    logic [CNT_W-1:0]      r_hw;
    logic [CNT_W-1:0]      n_hw;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_busy;
    logic                  r_pend;
    logic                  r_full;
    logic                  n_full;
    logic                  r_out_valid;
    t_out_word             r_res;
    t_out_word             n_res;
    t_out_word             r_out;
    t_probe                r_probe;
    t_probe                n_probe;
    t_probe                w_chain [0:SLOTS];
    t_probe                w_fin;
    logic                  w_accept;
    logic                  w_move;
    logic [DATA_WIDTH-1:0] w_val;
    logic [IDX_W-1:0]      w_p;
    logic [IDX_W-1:0]      w_used;

    assign w_accept = i_in_valid && !r_busy;
    assign w_move   = r_pend && (!r_out_valid || !i_out_stall);
    assign w_val    = i_in_word.value[DATA_WIDTH-1:0];
    assign w_p      = (32'(r_low) >= SLOTS) ? '0 : r_low;

    // Build the probe for an accepted command word
    always_comb begin
        n_probe.valid      = w_accept;
        n_probe.op         = OP_NONE;
        n_probe.value      = w_val;
        n_probe.target     = w_p;
        n_probe.idx        = '0;
        n_probe.hw         = r_hw;
        n_probe.removed    = '0;
        n_probe.free_found = 1'b0;
        n_probe.free_idx   = '0;
        n_probe.clr_found  = 1'b0;
        n_probe.clr_idx    = '0;
        n_probe.top_hit    = 1'b0;
        n_full             = 1'b0;
        case (i_in_word.kind)
            KIND_INSERT: begin
                if (w_val != '0) begin
                    if (32'(r_count) >= SLOTS) begin
                        n_full = 1'b1;
                    end else begin
                        n_probe.op = OP_INSERT;
                    end
                end
            end
            KIND_RM_SLOT: begin
                if (32'(i_in_word.slot) < SLOTS) begin
                    n_probe.op     = OP_RM_SLOT;
                    n_probe.target = IDX_W'(i_in_word.slot);
                end
            end
            KIND_RM_VALUE: begin
                if (w_val != '0) begin
                    n_probe.op = OP_RM_VALUE;
                end
            end
            default: begin
            end
        endcase
    end

    // Launch register and cell chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_full <= n_full;
        end
    end

    assign w_chain[0] = r_probe;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        sta_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_chain[g]),
            .o_probe (w_chain[g+1])
        );
    end

    assign w_fin = w_chain[SLOTS];

    // Wrap up the probe that leaves the last cell
    always_comb begin
        n_low           = r_low;
        n_hw            = r_hw;
        n_count         = r_count;
        w_used          = '0;
        n_res.status    = r_full ? ST_FULL : ST_IGNORED;
        case (w_fin.op)
            OP_INSERT: begin
                n_res.status = ST_DONE;
                w_used       = w_fin.target;
                n_count      = r_count + CNT_W'(1);
                if (CNT_W'(w_fin.target) >= r_hw) begin
                    n_hw = CNT_W'(w_fin.target) + CNT_W'(1);
                end
                n_low = w_fin.free_found ? w_fin.free_idx : '0;
            end
            OP_RM_SLOT, OP_RM_VALUE: begin
                if (w_fin.removed != '0) begin
                    n_res.status = ST_DONE;
                end
                n_count = r_count - w_fin.removed;
                if (w_fin.clr_found && (w_fin.clr_idx < r_low)) begin
                    n_low = w_fin.clr_idx;
                end
                if (w_fin.top_hit) begin
                    n_hw = r_hw - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        n_res.used_slot   = 6'(w_used);
        n_res.removed     = 7'(w_fin.removed);
        n_res.entry_total = 7'(n_count);
    end

    // Update table counters and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low       <= '0;
            r_hw        <= '0;
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fin.valid) begin
                r_low   <= n_low;
                r_hw    <= n_hw;
                r_count <= n_count;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_fin.valid) begin
                r_pend <= 1'b1;
            end else if (w_move) begin
                r_pend <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result words
    always_ff @(posedge i_clk) begin
        if (w_fin.valid) begin
            r_res <= n_res;
        end
        if (w_move) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= SLOTS)
        else $error("entry count above table size");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_busy)
        else $error("pending result without a command in flight");

    a_fin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin.valid |-> (r_busy && !r_pend))
        else $error("probe left the chain outside a command");

    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_probe.valid && r_busy))
        else $error("accepted command word did not launch a probe");

endmodule

`default_nettype wire

FILE: tb/tb_slot_table_allocator_top.sv
// Self-checking testbench for slot_table_allocator_top: predicts every result
// word from its own copy of the slot table and checks it as it is accepted.
// Depends on sta_pkg and the slot_table_allocator_top RTL.
`default_nettype none

module tb_slot_table_allocator_top
    import sta_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         RANDOM_ITEMS = 1630;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         HOLD_START   = 400;
    localparam int         HOLD_CYCLES  = 600;
    localparam int         QUIET_FIRST  = 700;
    localparam int         QUIET_LAST   = 950;

    typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} t_stim_mode;

    // Table predictor and queue of predicted result words
    class t_slot_table_scoreboard;
        logic [DATA_WIDTH-1:0] slot_data[SLOTS];
        bit                    slot_used[SLOTS];
        int unsigned           free_ptr;
        int unsigned           high_mark;
        int unsigned           entries;
        t_out_word             result_q[$];
        int                    accepted;
        int                    mismatches;

        function new();
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_data[i] = '0;
            end
            free_ptr   = 0;
            high_mark  = 0;
            entries    = 0;
            accepted   = 0;
            mismatches = 0;
        endfunction

        // Drop one occupied slot; the mark falls by exactly one at the top
        function void clear_slot(int unsigned s);
            slot_used[s] = 1'b0;
            slot_data[s] = '0;
            if (s < free_ptr)
                free_ptr = s;
            if (s + 1 == high_mark)
                high_mark--;
            entries--;
        endfunction

        function void note_command(t_in_word w);
            t_out_word   res;
            int unsigned top;
            int unsigned pos;
            res.status    = ST_IGNORED;
            res.used_slot = '0;
            res.removed   = '0;
            accepted++;
            case (w.kind)
                KIND_INSERT: begin
                    if (w.value != '0) begin
                        if (entries >= SLOTS) begin
                            res.status = ST_FULL;
                        end else begin
                            pos = (free_ptr >= SLOTS) ? 0 : free_ptr;
                            slot_data[pos] = w.value;
                            slot_used[pos] = 1'b1;
                            entries++;
                            if (pos >= high_mark)
                                high_mark = pos + 1;
                            // rescan for the lowest empty slot, zero when full
                            free_ptr = 0;
                            for (int i = 0; i < SLOTS; i++) begin
                                if (!slot_used[i]) begin
                                    free_ptr = i;
                                    break;
                                end
                            end
                            res.used_slot = IDX_W'(pos);
                            res.status    = ST_DONE;
                        end
                    end
                end
                KIND_RM_SLOT: begin
                    if (w.slot < high_mark && slot_used[w.slot]) begin
                        clear_slot(w.slot);
                        res.removed = 7'd1;
                        res.status  = ST_DONE;
                    end
                end
                KIND_RM_VALUE: begin
                    if (w.value != '0) begin
                        top = high_mark;
                        for (int unsigned i = 0; i < top && i < SLOTS; i++) begin
                            if (slot_used[i] && slot_data[i] == w.value) begin
                                clear_slot(i);
                                res.removed = res.removed + 7'd1;
                            end
                        end
                        if (res.removed != '0)
                            res.status = ST_DONE;
                    end
                end
                default: ;
            endcase
            res.entry_total = CNT_W'(entries);
            result_q.push_back(res);
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result word with none predicted: status %0d used %0d ",
                              "removed %0d total %0d"},
                             $realtime, got.status, got.used_slot, got.removed,
                             got.entry_total);
                return;
            end
            want = result_q.pop_front();
            if (got.status !== want.status || got.used_slot !== want.used_slot ||
                got.removed !== want.removed || got.entry_total !== want.entry_total) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected status %0d used %0d removed %0d total %0d, %s",
                             $realtime, want.status, want.used_slot, want.removed,
                             want.entry_total,
                             $sformatf("got status %0d used %0d removed %0d total %0d",
                                       got.status, got.used_slot, got.removed,
                                       got.entry_total));
            end
        endfunction
    endclass

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_word  in_word    = '0;
    logic      out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    t_slot_table_scoreboard sb = new();
    logic [DATA_WIDTH-1:0]  value_pool[8];
    int                     cycle_cnt = 0;
    int                     hold_left = 0;
    bit                     hold_done = 1'b0;

    slot_table_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Both sides run without idling inside this window of accepted words
    function automatic bit quiet_window();
        return sb.accepted >= QUIET_FIRST && sb.accepted < QUIET_LAST;
    endfunction

    // Receiver stall: one long hold-off, then random stalls
    always @(posedge i_clk) begin
        if (!hold_done && sb.accepted >= HOLD_START) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (quiet_window()) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < 30);
        end
    end

    // Sample the result word at the falling edge ahead of the edge that takes it
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            sb.check_result(o_out_word);
    end

    function automatic t_in_word mk_word(logic [1:0] kind, logic [31:0] value,
                                         logic [5:0] slot);
        t_in_word w;
        w.kind  = kind;
        w.value = value;
        w.slot  = slot;
        return w;
    endfunction

    // Offer one word, with an optional idle gap first; return once it is taken
    task automatic send_word(input t_in_word w);
        bit taken;
        if (!quiet_window() && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(70, 1)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        sb.note_command(w);
    endtask

    // Drop valid and hold until every predicted word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.result_q.size() > 0) @(posedge i_clk);
    endtask

    // Random word biased by the phase mode and the predicted table contents
    function automatic t_in_word pick_word(t_stim_mode mode);
        t_in_word w;
        int       roll;
        int       ins_pct;
        int       rms_pct;
        int       rmv_pct;
        int       s;
        case (mode)
            MODE_FILL: begin
                ins_pct = 85; rms_pct = 6;  rmv_pct = 6;
            end
            MODE_DRAIN: begin
                ins_pct = 20; rms_pct = 45; rmv_pct = 32;
            end
            default: begin
                ins_pct = 45; rms_pct = 25; rmv_pct = 26;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < ins_pct)
            w.kind = KIND_INSERT;
        else if (roll < ins_pct + rms_pct)
            w.kind = KIND_RM_SLOT;
        else if (roll < ins_pct + rms_pct + rmv_pct)
            w.kind = KIND_RM_VALUE;
        else
            w.kind = KIND_UNUSED;
        roll = $urandom_range(99);
        if (roll < 3)
            w.value = '0;
        else if (roll < 55)
            w.value = value_pool[$urandom_range(7)];
        else
            w.value = $urandom();
        // aim most value removals at a word that is in the table; the count
        // can run ahead of the occupied slots, so bound the search
        if (w.kind == KIND_RM_VALUE && sb.entries > 0 && $urandom_range(99) < 60) begin
            s = $urandom_range(SLOTS - 1);
            for (int k = 0; k < SLOTS && !sb.slot_used[s]; k++)
                s = (s + 1) % SLOTS;
            if (sb.slot_used[s])
                w.value = sb.slot_data[s];
        end
        if (sb.high_mark > 0 && $urandom_range(99) < 75)
            w.slot = IDX_W'($urandom_range(sb.high_mark - 1));
        else
            w.slot = IDX_W'($urandom_range(SLOTS - 1));
        return w;
    endfunction

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("slot_table_allocator_top: mismatch");
        $finish;
    end

    initial begin : stimulus
        t_stim_mode mode;
        int         phase_len;
        int         last_item;
        value_pool[0] = 32'hFFFF_FFFF;
        value_pool[1] = 32'h0000_0001;
        for (int i = 2; i < 8; i++)
            value_pool[i] = $urandom();

        // Hold reset, then release it at an edge
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: extremes, every kind, each corner of the table
        send_word(mk_word(KIND_INSERT,   32'h0000_0001, 6'd0));
        send_word(mk_word(KIND_INSERT,   32'hFFFF_FFFF, 6'd63));
        send_word(mk_word(KIND_INSERT,   32'h0000_0000, 6'd0));
        send_word(mk_word(KIND_INSERT,   32'hA5A5_A5A5, 6'd0));
        send_word(mk_word(KIND_INSERT,   32'hA5A5_A5A5, 6'd0));
        send_word(mk_word(KIND_INSERT,   32'h5A5A_5A5A, 6'd0));
        send_word(mk_word(KIND_RM_SLOT,  32'h0000_0000, 6'd1));
        send_word(mk_word(KIND_RM_SLOT,  32'hFFFF_FFFF, 6'd1));
        send_word(mk_word(KIND_RM_SLOT,  32'h0000_0000, 6'd63));
        send_word(mk_word(KIND_RM_SLOT,  32'h0000_0000, 6'd4));
        send_word(mk_word(KIND_INSERT,   32'h1234_5678, 6'd0));
        // empty slot under the mark: top removal still drops it by one only
        send_word(mk_word(KIND_RM_VALUE, 32'hA5A5_A5A5, 6'd0));
        send_word(mk_word(KIND_RM_VALUE, 32'h0000_0000, 6'd63));
        send_word(mk_word(KIND_RM_VALUE, 32'hDEAD_BEEF, 6'd0));
        send_word(mk_word(KIND_UNUSED,   32'hFFFF_FFFF, 6'd63));
        send_word(mk_word(KIND_UNUSED,   32'h0000_0000, 6'd0));
        send_word(mk_word(KIND_RM_SLOT,  32'h0000_0000, 6'd0));
        send_word(mk_word(KIND_RM_SLOT,  32'h0000_0000, 6'd1));
        send_word(mk_word(KIND_RM_SLOT,  32'h0000_0000, 6'd2));
        send_word(mk_word(KIND_INSERT,   32'h8000_0000, 6'd0));
        send_word(mk_word(KIND_RM_VALUE, 32'h8000_0000, 6'd0));
        wait_drained();

        // Random phases: fill up to full, mix, drain, and around again
        last_item = sb.accepted + RANDOM_ITEMS;
        mode = MODE_FILL;
        while (sb.accepted < last_item) begin
            phase_len = $urandom_range(160, 40);
            repeat (phase_len) send_word(pick_word(mode));
            if ($urandom_range(3) == 0)
                wait_drained();
            mode = (mode == MODE_DRAIN) ? MODE_FILL : t_stim_mode'(mode + 1);
        end

        // Drain, then allow one more command time for stray result words
        wait_drained();
        repeat (2 * SLOTS) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.result_q.size() == 0)
            $display("slot_table_allocator_top: match");
        else
            $display("slot_table_allocator_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
